// File: rtl/msas_pkg.sv
// Package: shared widths, register indexes, reset values and payload types.
package msas_pkg;

   localparam int unsigned NODES_DEFAULT  = 4;
   localparam int unsigned SEV_NODES      = 4;
   localparam int unsigned SEV_W          = 8;
   localparam int unsigned TIMER_W        = 16;
   localparam int unsigned NODE_IDX_W     = 2;
   localparam int unsigned NODE_SEL_W     = 3;
   localparam int unsigned COUNT_W        = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned CSR_INDEX_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_NODE_SEVERITIES = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALARM_HOLD      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REARM_WAIT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RAISE_HOLD      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOCKOUT         = 3'd4;

   localparam logic [31:0]        SEVERITIES_RESET = 32'h0106_0503;
   localparam logic [TIMER_W-1:0] ALARM_HOLD_RESET = 16'd50;
   localparam logic [TIMER_W-1:0] REARM_WAIT_RESET = 16'd300;
   localparam logic [TIMER_W-1:0] RAISE_HOLD_RESET = 16'd100;
   localparam logic [TIMER_W-1:0] LOCKOUT_RESET    = 16'd50;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic                  raise_alarm;
      logic [NODE_IDX_W-1:0] raised_node;
      logic [SEV_W-1:0]      raised_severity;
      logic                  clear_all;
      logic [COUNT_W-1:0]    active_count;
      logic [SEV_NODES-1:0]  active_mask;
   } rsp_type;

   typedef struct packed {
      logic                  tick;
      logic                  level_we;
      logic                  level;
   } node_ctl_type;

endpackage

// File: rtl/msas_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface msas_req_if import msas_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [NODE_IDX_W-1:0] node_index;
   logic                  motion_level;

   modport source (output valid, cmd, node_index, motion_level, input ready);
   modport sink   (input valid, cmd, node_index, motion_level, output ready);
endinterface

interface msas_rsp_if import msas_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  raise_alarm;
   logic [NODE_IDX_W-1:0] raised_node;
   logic [SEV_W-1:0]      raised_severity;
   logic                  clear_all;
   logic [COUNT_W-1:0]    active_count;
   logic [SEV_NODES-1:0]  active_mask;

   modport source (output valid, raise_alarm, raised_node, raised_severity, clear_all,
                   active_count, active_mask, input ready);
   modport sink   (input valid, raise_alarm, raised_node, raised_severity, clear_all,
                   active_count, active_mask, output ready);
endinterface

// File: rtl/msas_node.sv
// Per-node machine: start, armed, alarm hold and rearm wait with stored motion level.
module msas_node import msas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  node_ctl_type       ctl,
   input  logic [TIMER_W-1:0] alarm_hold,
   input  logic [TIMER_W-1:0] rearm_wait,
   output logic               in_alarm
);

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_ARMED = 2'd1,
      MODE_ALARM = 2'd2,
      MODE_WAIT  = 2'd3
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic               level_ff, level_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               expired;

   assign expired = (timer_ff == '0);

   always_comb begin
      mode_in  = mode_ff;
      timer_in = timer_ff;
      level_in = ctl.level_we ? ctl.level : level_ff;
      if (ctl.tick) begin
         case (mode_ff)
            MODE_START: begin
               mode_in = MODE_ARMED;
            end
            MODE_ARMED: begin
               if (level_ff) begin
                  mode_in  = MODE_ALARM;
                  timer_in = alarm_hold;
               end
            end
            MODE_ALARM: begin
               if (expired) begin
                  mode_in  = MODE_WAIT;
                  timer_in = rearm_wait;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            default: begin
               if (expired) begin
                  mode_in = MODE_ARMED;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
         endcase
      end
   end

   // state after the item being taken this cycle
   assign in_alarm = (mode_in == MODE_ALARM);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         level_ff <= 1'b0;
         timer_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         level_ff <= level_in;
         timer_ff <= timer_in;
      end
   end

endmodule

// File: rtl/multi_sensor_alarm_sequencer.sv
// Top level: node machines, severity pick, global alarm machine and result buffer.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    cmd, node_index, motion_level
//   rsp_chan  out   valid/ready    raise_alarm, raised_node, raised_severity,
//                                  clear_all, active_count, active_mask
//   csr_*     in    write enable   csr_index, csr_write_data
//
// One item per cycle while ready is high; each result is registered in the buffer.
// A two-entry result buffer keeps req_chan.ready high while one result waits.
// Synchronous active-high reset restores machines, CSRs and buffer valid flags.
// Ready drops only while both buffer entries are occupied.
module multi_sensor_alarm_sequencer import msas_pkg::*; #(
   parameter int unsigned NODES = NODES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   msas_req_if.sink               req_chan,
   msas_rsp_if.source             rsp_chan
);

   localparam int unsigned CNT_W = $clog2(NODES + 1);

   typedef enum logic [1:0] {
      G_START   = 2'd0,
      G_ARMED   = 2'd1,
      G_RAISED  = 2'd2,
      G_LOCKOUT = 2'd3
   } gmode_type;

   logic [31:0]        severities_ff;
   logic [TIMER_W-1:0] alarm_hold_ff, rearm_wait_ff, raise_hold_ff, lockout_ff;

   gmode_type          gmode_ff, gmode_in;
   logic [TIMER_W-1:0] gtimer_ff, gtimer_in;

   rsp_type            head_ff, head_in, tail_ff, tail_in, result;
   logic               head_valid_ff, head_valid_in, tail_valid_ff, tail_valid_in;

   logic               push, pop, tick;
   logic [NODES-1:0]   alarm;
   logic [CNT_W-1:0]   count_wide;
   logic [NODE_SEL_W-1:0] top_node;
   logic [SEV_W-1:0]   top_sev;
   logic               have_top;
   logic [SEV_NODES-1:0] mask;

   assign req_chan.ready = !tail_valid_ff;
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign tick = push && (req_chan.cmd == CMD_TICK);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         severities_ff <= SEVERITIES_RESET;
         alarm_hold_ff <= ALARM_HOLD_RESET;
         rearm_wait_ff <= REARM_WAIT_RESET;
         raise_hold_ff <= RAISE_HOLD_RESET;
         lockout_ff    <= LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_NODE_SEVERITIES: severities_ff <= csr_write_data[31:0];
            REG_ALARM_HOLD:      alarm_hold_ff <= csr_write_data[TIMER_W-1:0];
            REG_REARM_WAIT:      rearm_wait_ff <= csr_write_data[TIMER_W-1:0];
            REG_RAISE_HOLD:      raise_hold_ff <= csr_write_data[TIMER_W-1:0];
            REG_LOCKOUT:         lockout_ff    <= csr_write_data[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // node machines
   for (genvar n = 0; n < NODES; n++) begin : g_node
      node_ctl_type ctl;
      assign ctl.tick     = tick;
      assign ctl.level_we = push && (req_chan.cmd == CMD_REPORT) && (n < SEV_NODES) &&
                            (req_chan.node_index == NODE_IDX_W'(n));
      assign ctl.level    = req_chan.motion_level;

      msas_node u_node (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .alarm_hold (alarm_hold_ff),
         .rearm_wait (rearm_wait_ff),
         .in_alarm   (alarm[n])
      );
   end

   // count, mask and highest severity, ties to the lower index
   always_comb begin
      logic [SEV_W-1:0] sev;
      count_wide = '0;
      mask       = '0;
      top_node   = '0;
      top_sev    = '0;
      have_top   = 1'b0;
      for (int unsigned n = 0; n < NODES; n++) begin
         sev = (n < SEV_NODES) ? severities_ff[SEV_W*(n % SEV_NODES) +: SEV_W] : '0;
         if (alarm[n]) begin
            count_wide = count_wide + 1'b1;
            if (n < SEV_NODES) begin
               mask[n % SEV_NODES] = 1'b1;
            end
            if (!have_top || sev > top_sev) begin
               have_top = 1'b1;
               top_sev  = sev;
               top_node = NODE_SEL_W'(n);
            end
         end
      end
   end

   // global machine and result
   always_comb begin
      gmode_in  = gmode_ff;
      gtimer_in = gtimer_ff;
      result    = '0;
      result.active_count = (count_wide > 3'd7) ? 3'd7 : COUNT_W'(count_wide);
      result.active_mask  = mask;
      if (tick) begin
         case (gmode_ff)
            G_START: begin
               gmode_in = G_ARMED;
            end
            G_ARMED: begin
               if (have_top) begin
                  gmode_in               = G_RAISED;
                  gtimer_in              = raise_hold_ff;
                  result.raise_alarm     = 1'b1;
                  result.raised_node     = top_node[NODE_IDX_W-1:0];
                  result.raised_severity = top_sev;
               end
            end
            G_RAISED: begin
               if (gtimer_ff == '0) begin
                  gmode_in         = G_LOCKOUT;
                  gtimer_in        = lockout_ff;
                  result.clear_all = 1'b1;
               end else begin
                  gtimer_in = gtimer_ff - 1'b1;
               end
            end
            default: begin
               if (gtimer_ff == '0) begin
                  gmode_in = G_ARMED;
               end else begin
                  gtimer_in = gtimer_ff - 1'b1;
               end
            end
         endcase
      end
   end

   // result buffer: head drives the port, tail catches a transfer while head waits
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else begin
            head_in       = result;
            head_valid_in = push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            tail_in       = result;
            tail_valid_in = 1'b1;
         end else begin
            head_in       = result;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         gmode_ff      <= G_START;
         gtimer_ff     <= '0;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         gmode_ff      <= gmode_in;
         gtimer_ff     <= gtimer_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   assign rsp_chan.valid           = head_valid_ff;
   assign rsp_chan.raise_alarm     = head_ff.raise_alarm;
   assign rsp_chan.raised_node     = head_ff.raised_node;
   assign rsp_chan.raised_severity = head_ff.raised_severity;
   assign rsp_chan.clear_all       = head_ff.clear_all;
   assign rsp_chan.active_count    = head_ff.active_count;
   assign rsp_chan.active_mask     = head_ff.active_mask;

   a_raise_clear_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.raise_alarm && rsp_chan.clear_all))
      else $error("raise and clear in one result");

   a_raise_has_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.raise_alarm) |-> (rsp_chan.active_count != 3'd0))
      else $error("raise without an active node");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && tail_valid_ff))
      else $error("ready low with buffer space");

   a_tail_moves_up: assert property (@(posedge clock) disable iff (reset)
      (pop && tail_valid_ff) |=> (rsp_chan.valid && !tail_valid_ff))
      else $error("buffered result lost");

endmodule
